// ===== src/cbs_pkg.sv =====
// Shared types and constants of the constant bandwidth server budget tracker.
package cbs_pkg;

    localparam int TIME_W     = 32;
    localparam int MB_W       = 31;
    localparam int ALU_W      = TIME_W + 1;
    localparam int CNT_W      = $clog2(TIME_W);
    localparam int SHIFT_W    = 5;
    localparam int OP_W       = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [TIME_W-1:0] RST_SERVER_PERIOD = TIME_W'(1000);
    localparam logic [MB_W-1:0]   RST_MAX_BUDGET    = MB_W'(100);

    // Register index, taken from the word address of the configuration port.
    localparam logic REG_SERVER_PERIOD = 1'b0;
    localparam logic REG_MAX_BUDGET    = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_INIT       = 3'd0,
        OP_PUSH       = 3'd1,
        OP_JOB_BEGIN  = 3'd2,
        OP_JOB_END    = 3'd3,
        OP_SWITCH_IN  = 3'd4,
        OP_SWITCH_OUT = 3'd5,
        OP_EXPIRY     = 3'd6
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT_NORM,
        S_DIV,
        S_MUL,
        S_PUSH_DIFF,
        S_PUSH_CMP,
        S_PUSH_FILL,
        S_CHG_USED,
        S_CHG_CMP1,
        S_CHG_SUB,
        S_CHG_CMP2,
        S_CHG_DEC,
        S_CHG_EXC,
        S_CHG_DL,
        S_CHG_CB,
        S_CHG_RS,
        S_CHG_REL,
        S_HALT_FIN,
        S_EXP_DL,
        S_EXP_REL,
        S_DONE
    } eng_state_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] now;
        logic              more;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic [MB_W-1:0]   max_budget;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic ack;
    } eng_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } eng_sts_t;

    typedef struct packed {
        logic                     dl_upd;
        logic signed [TIME_W-1:0] rel;
        logic                     tl_valid;
        logic [TIME_W-1:0]        tl;
        logic                     stop;
        logic                     resched;
        logic                     active;
        logic [TIME_W-1:0]        budget;
    } res_t;

endpackage

// ===== src/cbs_cfg_regs.sv =====
// Configuration registers behind the APB-style port: server period and full budget.
module cbs_cfg_regs
    import cbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [TIME_W-1:0] period_reg;
    logic [MB_W-1:0]   mb_reg;
    logic              wr_en;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= RST_SERVER_PERIOD;
            mb_reg     <= RST_MAX_BUDGET;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_SERVER_PERIOD)
            begin
                period_reg <= pwdata[TIME_W-1:0];
            end
            else
            begin
                mb_reg <= pwdata[MB_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == REG_SERVER_PERIOD)
        begin
            prdata = period_reg;
        end
        else
        begin
            prdata = CFG_DATA_W'(mb_reg);
        end
    end

    assign cfg.period     = period_reg;
    assign cfg.max_budget = mb_reg;

endmodule

// ===== src/cbs_addsub.sv =====
// Shared add/subtract unit; on subtraction the carry out is set when a >= b.
module cbs_addsub
    import cbs_pkg::*;
(
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    input  logic             sub,
    output logic [ALU_W-1:0] sum,
    output logic             carry
);

    logic [ALU_W-1:0] b_eff;

    assign b_eff        = sub ? ~b : b;
    assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + (ALU_W + 1)'(sub);

endmodule

// ===== src/cbs_engine.sv =====
// Sequencer and server state: the arithmetic steps of an event share one adder.
module cbs_engine
    import cbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  eng_ctl_t ctl,
    input  item_t    item,
    input  cfg_t     cfg,
    output eng_sts_t sts,
    output res_t     res
);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TIME_W - 1);

    eng_state_t state_reg, state_next;

    op_t               op_reg, op_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              more_reg, more_next;

    logic [TIME_W-1:0]  rs_reg, rs_next;
    logic [TIME_W-1:0]  dl_reg, dl_next;
    logic [TIME_W-1:0]  cb_reg, cb_next;
    logic               active_reg, active_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [TIME_W-1:0]  sbw_reg, sbw_next;

    logic [TIME_W-1:0] opa_reg, opa_next;
    logic [TIME_W-1:0] opb_reg, opb_next;
    logic [TIME_W-1:0] acc_reg, acc_next;
    logic [TIME_W-1:0] used_reg, used_next;
    logic [TIME_W-1:0] excess_reg, excess_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              dl_upd_reg, dl_upd_next;
    logic [TIME_W-1:0] rel_reg, rel_next;
    logic              tl_valid_reg, tl_valid_next;
    logic [TIME_W-1:0] tl_reg, tl_next;
    logic              stop_reg, stop_next;
    logic              resched_reg, resched_next;

    logic [ALU_W-1:0]  alu_a, alu_b, alu_sum;
    logic              alu_sub, alu_carry;
    logic [TIME_W-1:0] sum32;
    logic [TIME_W-1:0] mb32;
    logic [TIME_W-1:0] lhs;
    logic [ALU_W-1:0]  div_a;
    logic [TIME_W-1:0] mul_addend;
    logic              mb_zero;
    logic              last_step;
    op_t               op_in;

    assign op_in      = op_t'(item.op);
    assign mb32       = TIME_W'(cfg.max_budget);
    assign mb_zero    = (cfg.max_budget == '0);
    assign lhs        = cb_reg << shift_reg;
    assign div_a      = {acc_reg, opb_reg[TIME_W-1]};
    assign mul_addend = opb_reg[0] ? opa_reg : '0;
    assign last_step  = (cnt_reg == LAST_STEP);
    assign sum32      = alu_sum[TIME_W-1:0];

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_PUSH_DIFF:
            begin
                alu_a = ALU_W'(dl_reg);  alu_b = ALU_W'(now_reg);     alu_sub = 1'b1;
            end
            S_MUL:
            begin
                alu_a = ALU_W'(acc_reg); alu_b = ALU_W'(mul_addend);
            end
            S_DIV:
            begin
                alu_a = div_a;           alu_b = ALU_W'(opa_reg);     alu_sub = 1'b1;
            end
            S_PUSH_CMP:
            begin
                alu_a = ALU_W'(lhs);     alu_b = ALU_W'(acc_reg);     alu_sub = 1'b1;
            end
            S_PUSH_FILL:
            begin
                alu_a = ALU_W'(now_reg); alu_b = ALU_W'(cfg.period);
            end
            S_CHG_USED:
            begin
                alu_a = ALU_W'(now_reg); alu_b = ALU_W'(rs_reg);      alu_sub = 1'b1;
            end
            S_CHG_CMP1:
            begin
                alu_a = ALU_W'(used_reg); alu_b = ALU_W'(cb_reg);     alu_sub = 1'b1;
            end
            S_CHG_SUB:
            begin
                alu_a = ALU_W'(cb_reg);  alu_b = ALU_W'(used_reg);    alu_sub = 1'b1;
            end
            S_CHG_CMP2:
            begin
                alu_a = ALU_W'(mb32);    alu_b = ALU_W'(used_reg);    alu_sub = 1'b1;
            end
            S_CHG_DEC:
            begin
                alu_a = ALU_W'(used_reg); alu_b = ALU_W'(1);          alu_sub = 1'b1;
            end
            S_CHG_EXC:
            begin
                alu_a = ALU_W'(acc_reg); alu_b = ALU_W'(1);
            end
            S_CHG_DL, S_EXP_DL:
            begin
                alu_a = ALU_W'(dl_reg);  alu_b = ALU_W'(cfg.period);
            end
            S_CHG_CB:
            begin
                alu_a = ALU_W'(mb32);    alu_b = ALU_W'(excess_reg);  alu_sub = 1'b1;
            end
            S_CHG_RS:
            begin
                alu_a = ALU_W'(now_reg); alu_b = ALU_W'(excess_reg);  alu_sub = 1'b1;
            end
            S_CHG_REL:
            begin
                alu_a = ALU_W'(dl_reg);  alu_b = ALU_W'(used_reg);    alu_sub = 1'b1;
            end
            S_EXP_REL:
            begin
                alu_a = ALU_W'(dl_reg);  alu_b = ALU_W'(now_reg);     alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    cbs_addsub u_addsub (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    case (op_in)
                        OP_INIT:       state_next = mb_zero ? S_DONE : S_INIT_NORM;
                        OP_PUSH:       state_next = active_reg ? S_DONE : S_PUSH_DIFF;
                        OP_JOB_END:    state_next = (rs_reg == '0) ? S_HALT_FIN : S_CHG_USED;
                        OP_SWITCH_OUT:
                        begin
                            if (!active_reg)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = (rs_reg == '0) ? S_HALT_FIN : S_CHG_USED;
                            end
                        end
                        OP_EXPIRY:     state_next = S_EXP_DL;
                        default:       state_next = S_DONE;
                    endcase
                end
            end
            S_INIT_NORM: state_next = opb_reg[MB_W-1] ? S_DIV : S_INIT_NORM;
            S_DIV:
            begin
                if (last_step)
                begin
                    state_next = (op_reg == OP_INIT) ? S_DONE : S_CHG_EXC;
                end
            end
            S_PUSH_DIFF: state_next = (alu_carry && sum32 != '0) ? S_MUL : S_PUSH_FILL;
            S_MUL:
            begin
                if (last_step)
                begin
                    state_next = (op_reg == OP_PUSH) ? S_PUSH_CMP : S_CHG_CB;
                end
            end
            // Carry set means the scaled budget is not below the bandwidth term.
            S_PUSH_CMP:  state_next = alu_carry ? S_PUSH_FILL : S_DONE;
            S_PUSH_FILL: state_next = S_DONE;
            S_CHG_USED:  state_next = S_CHG_CMP1;
            S_CHG_CMP1:  state_next = alu_carry ? S_CHG_CMP2 : S_CHG_SUB;
            S_CHG_SUB:   state_next = S_HALT_FIN;
            S_CHG_CMP2:  state_next = (!alu_carry && !mb_zero) ? S_CHG_DEC : S_CHG_DL;
            S_CHG_DEC:   state_next = S_DIV;
            S_CHG_EXC:   state_next = S_CHG_DL;
            S_CHG_DL:    state_next = S_MUL;
            S_CHG_CB:    state_next = S_CHG_RS;
            S_CHG_RS:    state_next = S_CHG_REL;
            S_CHG_REL:   state_next = S_HALT_FIN;
            S_HALT_FIN:  state_next = S_DONE;
            S_EXP_DL:    state_next = S_EXP_REL;
            S_EXP_REL:   state_next = S_DONE;
            S_DONE:      state_next = ctl.ack ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath and result updates.
    always_comb
    begin
        op_next       = op_reg;
        now_next      = now_reg;
        more_next     = more_reg;
        rs_next       = rs_reg;
        dl_next       = dl_reg;
        cb_next       = cb_reg;
        active_next   = active_reg;
        shift_next    = shift_reg;
        sbw_next      = sbw_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        acc_next      = acc_reg;
        used_next     = used_reg;
        excess_next   = excess_reg;
        cnt_next      = cnt_reg;
        dl_upd_next   = dl_upd_reg;
        rel_next      = rel_reg;
        tl_valid_next = tl_valid_reg;
        tl_next       = tl_reg;
        stop_next     = stop_reg;
        resched_next  = resched_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    op_next       = op_in;
                    now_next      = item.now;
                    more_next     = item.more;
                    dl_upd_next   = 1'b0;
                    rel_next      = '0;
                    tl_valid_next = 1'b0;
                    tl_next       = '0;
                    stop_next     = 1'b0;
                    resched_next  = 1'b0;
                    case (op_in)
                        OP_INIT:
                        begin
                            rs_next    = '0;
                            cb_next    = mb32;
                            shift_next = '0;
                            dl_next    = '0;
                            opb_next   = mb32;
                        end
                        OP_JOB_BEGIN, OP_SWITCH_IN:
                        begin
                            // A start time of zero leaves the server looking idle.
                            if ((op_in == OP_JOB_BEGIN || active_reg) && rs_reg == '0)
                            begin
                                rs_next       = item.now;
                                tl_valid_next = 1'b1;
                                tl_next       = cb_reg;
                            end
                        end
                        OP_JOB_END:
                        begin
                            stop_next = 1'b1;
                        end
                        OP_SWITCH_OUT:
                        begin
                            stop_next = active_reg;
                        end
                        default:
                        begin
                            stop_next = 1'b0;
                        end
                    endcase
                end
            end
            S_INIT_NORM:
            begin
                if (opb_reg[MB_W-1])
                begin
                    opa_next = cfg.period;
                    acc_next = '0;
                    cnt_next = '0;
                end
                else
                begin
                    opb_next   = opb_reg << 1;
                    shift_next = SHIFT_W'(shift_reg + 1'b1);
                end
            end
            S_DIV:
            begin
                // Restoring division; a zero divisor yields an all-ones quotient.
                acc_next = alu_carry ? sum32 : div_a[TIME_W-1:0];
                opb_next = {opb_reg[TIME_W-2:0], alu_carry};
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (last_step && op_reg == OP_INIT)
                begin
                    sbw_next = {opb_reg[TIME_W-2:0], alu_carry};
                end
            end
            S_PUSH_DIFF:
            begin
                opa_next = sum32;
                opb_next = sbw_reg;
                acc_next = '0;
                cnt_next = '0;
            end
            S_MUL:
            begin
                acc_next = sum32;
                opa_next = opa_reg << 1;
                opb_next = opb_reg >> 1;
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (last_step && op_reg != OP_PUSH)
                begin
                    dl_next = sum32;
                end
            end
            S_PUSH_CMP:
            begin
                active_next = 1'b1;
            end
            S_PUSH_FILL:
            begin
                dl_next      = sum32;
                cb_next      = mb32;
                dl_upd_next  = 1'b1;
                rel_next     = cfg.period;
                resched_next = 1'b1;
                active_next  = 1'b1;
            end
            S_CHG_USED:
            begin
                used_next = sum32;
            end
            S_CHG_CMP1:
            begin
                excess_next = sum32;
            end
            S_CHG_SUB:
            begin
                cb_next = sum32;
            end
            S_CHG_CMP2:
            begin
                if (alu_carry || mb_zero)
                begin
                    // No catch-up periods: the multiply adds nothing.
                    opb_next = '0;
                    if (!alu_carry)
                    begin
                        excess_next = used_reg;
                    end
                end
            end
            S_CHG_DEC:
            begin
                opb_next = sum32;
                opa_next = mb32;
                acc_next = '0;
                cnt_next = '0;
            end
            S_CHG_EXC:
            begin
                excess_next = sum32;
            end
            S_CHG_DL:
            begin
                acc_next = sum32;
                opa_next = cfg.period;
                cnt_next = '0;
            end
            S_CHG_CB:
            begin
                cb_next = sum32;
            end
            S_CHG_RS:
            begin
                used_next = sum32;
            end
            S_CHG_REL:
            begin
                rel_next     = sum32;
                dl_upd_next  = 1'b1;
                resched_next = 1'b1;
            end
            S_HALT_FIN:
            begin
                rs_next = '0;
                if (op_reg == OP_JOB_END)
                begin
                    active_next = more_reg;
                end
            end
            S_EXP_DL:
            begin
                dl_next = sum32;
            end
            S_EXP_REL:
            begin
                rel_next      = sum32;
                rs_next       = now_reg;
                cb_next       = mb32;
                tl_next       = mb32;
                tl_valid_next = 1'b1;
                dl_upd_next   = 1'b1;
                resched_next  = 1'b1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rs_reg     <= '0;
            dl_reg     <= '0;
            cb_reg     <= TIME_W'(RST_MAX_BUDGET);
            active_reg <= 1'b0;
            shift_reg  <= '0;
            sbw_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rs_reg     <= rs_next;
            dl_reg     <= dl_next;
            cb_reg     <= cb_next;
            active_reg <= active_next;
            shift_reg  <= shift_next;
            sbw_reg    <= sbw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        now_reg      <= now_next;
        more_reg     <= more_next;
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        acc_reg      <= acc_next;
        used_reg     <= used_next;
        excess_reg   <= excess_next;
        cnt_reg      <= cnt_next;
        dl_upd_reg   <= dl_upd_next;
        rel_reg      <= rel_next;
        tl_valid_reg <= tl_valid_next;
        tl_reg       <= tl_next;
        stop_reg     <= stop_next;
        resched_reg  <= resched_next;
    end

    assign sts.idle = (state_reg == S_IDLE);
    assign sts.done = (state_reg == S_DONE);

    assign res.dl_upd   = dl_upd_reg;
    assign res.rel      = rel_reg;
    assign res.tl_valid = tl_valid_reg;
    assign res.tl       = tl_reg;
    assign res.stop     = stop_reg;
    assign res.resched  = resched_reg;
    assign res.active   = active_reg;
    assign res.budget   = cb_reg;

`ifndef SYNTHESIS
    a_ack_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ack |-> state_reg == S_DONE)
        else $error("result handed over outside the done state");

    a_mul_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && cnt_reg == LAST_STEP)
        |=> (state_reg == S_PUSH_CMP || state_reg == S_CHG_CB))
        else $error("multiply did not finish after its last step");

    a_halt_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HALT_FIN |=> rs_reg == '0)
        else $error("run start not cleared after a timer halt");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && opa_reg != '0) |-> acc_reg < opa_reg)
        else $error("division remainder reached the divisor");
`endif

endmodule

// ===== src/cbs_budget_tracker.sv =====
// Top level of the constant bandwidth server budget tracker.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall   | event_op, now_cycle, more_jobs_waiting
//  out     | output    | out_valid / out_stall | deadline_update .. budget_left
//  cfg     | input     | psel/penable/pready   | paddr, pwdata, prdata
//
// An event holds the engine from its transfer until its result is handed over; the long
// paths are the 32-step shift-add multiply and the 32-step restoring divide on the shared
// adder: a bandwidth-rule push multiplies, an init divides, an overrun stop may do both.
// in_stall is high from the transfer of an event until its result is loaded into the
// output register; a new event is taken while that result still waits on out_stall.
// Reset restores the register defaults and the idle server state; no clearing pass.
module cbs_budget_tracker
    import cbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          event_op,
    input  logic [TIME_W-1:0]        now_cycle,
    input  logic                     more_jobs_waiting,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     deadline_update,
    output logic signed [TIME_W-1:0] relative_deadline,
    output logic                     timer_load_valid,
    output logic [TIME_W-1:0]        timer_load,
    output logic                     timer_stop,
    output logic                     reschedule,
    output logic                     server_active,
    output logic [TIME_W-1:0]        budget_left,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0]    pwdata,
    output logic [CFG_DATA_W-1:0]    prdata,
    output logic                     pready
);

    cfg_t     cfg;
    eng_ctl_t ctl;
    eng_sts_t sts;
    item_t    item;
    res_t     eng_res;
    res_t     res_out_reg;
    logic     out_valid_reg, out_valid_next;
    logic     out_free;

    cbs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign item.op   = event_op;
    assign item.now  = now_cycle;
    assign item.more = more_jobs_waiting;

    assign in_stall  = !sts.idle;
    assign out_free  = !out_valid_reg || !out_stall;
    assign ctl.start = in_valid && sts.idle;
    assign ctl.ack   = sts.done && out_free;

    cbs_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .item  (item),
        .cfg   (cfg),
        .sts   (sts),
        .res   (eng_res)
    );

    always_comb
    begin
        if (ctl.ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ack)
        begin
            res_out_reg <= eng_res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign deadline_update   = res_out_reg.dl_upd;
    assign relative_deadline = res_out_reg.rel;
    assign timer_load_valid  = res_out_reg.tl_valid;
    assign timer_load        = res_out_reg.tl;
    assign timer_stop        = res_out_reg.stop;
    assign reschedule        = res_out_reg.resched;
    assign server_active     = res_out_reg.active;
    assign budget_left       = res_out_reg.budget;

endmodule
